FILE: rtl/rcfrp_pkg.sv
// Shared types and constants for the radio-control frame receive parser.
`default_nettype none

package rcfrp_pkg;

    localparam int unsigned CHANNEL_COUNT = 10;
    localparam int unsigned CH_W          = 4;
    localparam int unsigned CHAN_W        = 16;
    localparam int unsigned PEND_DEPTH    = 2 * CHANNEL_COUNT;
    localparam int unsigned PEND_ADDR_W   = CH_W + 1;
    localparam int unsigned STATUS_W      = 3;
    localparam int unsigned OUT_DATA_W    = STATUS_W + CHANNEL_COUNT * CHAN_W;
    localparam int unsigned OUT_TDATA_W   = ((OUT_DATA_W + 7) / 8) * 8;

    localparam logic [15:0]   HEADER_WORD        = 16'hAAAF;
    localparam logic [7:0]    RC_FUNCTION        = 8'h03;
    localparam logic [7:0]    FIRST_CHANNEL_BYTE = 8'd4;
    localparam logic [7:0]    MIN_BODY_BYTES     = 8'd24;
    localparam logic [CH_W-1:0] LAST_CHANNEL     = CH_W'(CHANNEL_COUNT - 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_CSUM_BAD  = 3'd1,
        ST_HDR_BAD   = 3'd2,
        ST_OTHER_FN  = 3'd3,
        ST_TOO_SHORT = 3'd4
    } status_t;

    typedef logic [CHAN_W-1:0] chan_t;

endpackage

`default_nettype wire

FILE: rtl/rc_frame_receive_parser.sv
// Radio-control frame receive parser: checksum, header and channel commit.
// A rejected frame gives its result in the cycle after the frame-end transfer;
// an accepted frame, once its 10-entry copy out of RAM is done and the output is free.
// Throughput: one byte per cycle; a frame-end byte waits while a copy is in
// progress or awaits output, or the result register is full and not being taken.
// Pending channels sit in a two-bank RAM, banks swap on each accepted frame.
// Reset clears frame state, committed channels and handshake state at once.
`default_nettype none

module rc_frame_receive_parser #(
    parameter int unsigned MAX_FRAME_BYTES = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // frame_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [rcfrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
    // [2:0] status, then throttle, yaw, roll, pitch, aux_one .. aux_six (16 bits each)
);

    logic [7:0]  byte_index_reg;
    logic [7:0]  sum_reg;
    logic [15:0] header_reg;
    logic [7:0]  func_reg;
    logic [7:0]  hi_byte_reg;
    logic        bank_reg;

    logic                        sweep_active_reg;
    logic [rcfrp_pkg::CH_W-1:0]  sweep_ch_reg;
    logic                        sweep_bank_reg;
    logic                        rd_valid_reg;
    logic [rcfrp_pkg::CH_W-1:0]  rd_ch_reg;
    logic                        done_reg;

    rcfrp_pkg::chan_t committed_reg [rcfrp_pkg::CHANNEL_COUNT];
    rcfrp_pkg::chan_t chan_out_reg  [rcfrp_pkg::CHANNEL_COUNT];
    rcfrp_pkg::status_t status_reg;
    logic               m_valid_reg;
    logic               m_valid_next;

    logic               busy;
    logic               out_free;
    logic               in_accept;
    logic               end_accept;
    logic               byte_accept;
    rcfrp_pkg::status_t status_now;
    logic               commit;
    logic               emit_fail;
    logic               emit_ok;

    logic                               is_chan;
    logic [4:0]                         chan_off;
    logic [rcfrp_pkg::CH_W-1:0]         wr_ch;
    logic                               wr_en;
    logic [rcfrp_pkg::PEND_ADDR_W-1:0]  wr_addr;
    logic [rcfrp_pkg::PEND_ADDR_W-1:0]  rd_addr;
    rcfrp_pkg::chan_t                   rd_data;

    assign busy          = sweep_active_reg || rd_valid_reg || done_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s_axis_tlast || (!busy && out_free);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign end_accept    = in_accept && s_axis_tlast;
    assign byte_accept   = in_accept && !s_axis_tlast;

    always_comb begin
        if (s_axis_tdata != sum_reg) begin
            status_now = rcfrp_pkg::ST_CSUM_BAD;
        end else if (header_reg != rcfrp_pkg::HEADER_WORD) begin
            status_now = rcfrp_pkg::ST_HDR_BAD;
        end else if (func_reg != rcfrp_pkg::RC_FUNCTION) begin
            status_now = rcfrp_pkg::ST_OTHER_FN;
        end else if (byte_index_reg < rcfrp_pkg::MIN_BODY_BYTES) begin
            status_now = rcfrp_pkg::ST_TOO_SHORT;
        end else begin
            status_now = rcfrp_pkg::ST_ACCEPTED;
        end
    end

    assign commit    = end_accept && (status_now == rcfrp_pkg::ST_ACCEPTED);
    assign emit_fail = end_accept && (status_now != rcfrp_pkg::ST_ACCEPTED);
    assign emit_ok   = done_reg && out_free;

    assign is_chan  = (byte_index_reg >= rcfrp_pkg::FIRST_CHANNEL_BYTE) &&
                      (byte_index_reg <  rcfrp_pkg::MIN_BODY_BYTES);
    assign chan_off = byte_index_reg[4:0] - rcfrp_pkg::FIRST_CHANNEL_BYTE[4:0];
    assign wr_ch    = chan_off[4:1];
    assign wr_en    = byte_accept && is_chan && chan_off[0];
    assign wr_addr  = {wr_ch, bank_reg};
    assign rd_addr  = {sweep_ch_reg, sweep_bank_reg};

    rcfrp_ram #(
        .DATA_W (rcfrp_pkg::CHAN_W),
        .DEPTH  (rcfrp_pkg::PEND_DEPTH)
    ) u_pend_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({hi_byte_reg, s_axis_tdata}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
            sum_reg        <= '0;
            header_reg     <= '0;
            func_reg       <= '0;
            bank_reg       <= 1'b0;
        end else if (end_accept) begin
            byte_index_reg <= '0;
            sum_reg        <= '0;
            header_reg     <= '0;
            func_reg       <= '0;
            if (commit) begin
                bank_reg <= !bank_reg;
            end
        end else if (byte_accept) begin
            sum_reg <= sum_reg + s_axis_tdata;
            if (byte_index_reg < MAX_FRAME_BYTES[7:0]) begin
                byte_index_reg <= byte_index_reg + 8'd1;
            end
            if (byte_index_reg == 8'd0) begin
                header_reg[15:8] <= s_axis_tdata;
            end
            if (byte_index_reg == 8'd1) begin
                header_reg[7:0] <= s_axis_tdata;
            end
            if (byte_index_reg == 8'd2) begin
                func_reg <= s_axis_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_accept && is_chan && !chan_off[0]) begin
            hi_byte_reg <= s_axis_tdata;
        end
    end

    // Copy committed bank out of RAM
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_active_reg <= 1'b0;
            sweep_ch_reg     <= '0;
            sweep_bank_reg   <= 1'b0;
            rd_valid_reg     <= 1'b0;
            rd_ch_reg        <= '0;
            done_reg         <= 1'b0;
            for (int k = 0; k < rcfrp_pkg::CHANNEL_COUNT; k++) begin
                committed_reg[k] <= '0;
            end
        end else begin
            rd_valid_reg <= sweep_active_reg;
            rd_ch_reg    <= sweep_ch_reg;
            if (commit) begin
                sweep_active_reg <= 1'b1;
                sweep_ch_reg     <= '0;
                sweep_bank_reg   <= bank_reg;
            end else if (sweep_active_reg) begin
                sweep_ch_reg <= sweep_ch_reg + 1'b1;
                if (sweep_ch_reg == rcfrp_pkg::LAST_CHANNEL) begin
                    sweep_active_reg <= 1'b0;
                end
            end
            if (rd_valid_reg) begin
                committed_reg[rd_ch_reg] <= rd_data;
                if (rd_ch_reg == rcfrp_pkg::LAST_CHANNEL) begin
                    done_reg <= 1'b1;
                end
            end else if (emit_ok) begin
                done_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fail || emit_ok) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fail || emit_ok) begin
            status_reg <= emit_ok ? rcfrp_pkg::ST_ACCEPTED : status_now;
            for (int k = 0; k < rcfrp_pkg::CHANNEL_COUNT; k++) begin
                chan_out_reg[k] <= committed_reg[k];
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[rcfrp_pkg::STATUS_W-1:0] = status_reg;
        for (int k = 0; k < rcfrp_pkg::CHANNEL_COUNT; k++) begin
            m_axis_tdata[rcfrp_pkg::STATUS_W + rcfrp_pkg::CHAN_W*k +: rcfrp_pkg::CHAN_W] =
                chan_out_reg[k];
        end
    end

    a_no_end_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        end_accept |-> !busy)
        else $error("frame end taken during channel copy");

    a_copy_then_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_valid_reg && rd_ch_reg == rcfrp_pkg::LAST_CHANNEL) |=> done_reg)
        else $error("copy finished without done flag");

    a_sweep_old_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_active_reg |-> (sweep_bank_reg != bank_reg))
        else $error("copy reads the bank being filled");

    a_sweep_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sweep_active_reg && done_reg))
        else $error("copy active with done flag set");

endmodule

`default_nettype wire

FILE: rtl/rcfrp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module rcfrp_ram #(
    parameter int unsigned DATA_W = 16,
    parameter int unsigned DEPTH  = 20,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire
